[rtl/mcitt_pkg.sv]
// Shared types and constants for the multi-channel interval timer table.
`default_nettype none

package mcitt_pkg;

   localparam int NUM_SLOTS   = 16;
   localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int MAX_RESULTS = 32;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int REQ_DATA_W  = 104;
   localparam int RSP_DATA_W  = 8;

   localparam logic [1:0] OP_START    = 2'd0;
   localparam logic [1:0] OP_KILL     = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_KILL_ALL = 2'd3;

   localparam logic [1:0] KIND_STARTED = 2'd0;
   localparam logic [1:0] KIND_NOFREE  = 2'd1;
   localparam logic [1:0] KIND_FIRED   = 2'd2;
   localparam logic [1:0] KIND_KILLED  = 2'd3;

   typedef struct packed {
      logic [31:0] interval;
      logic [32:0] deadline;
      logic [32:0] expiry;
      logic        never_expires;
      logic        fire_enable;
      logic        kill_enable;
   } slot_rec_type;

   typedef struct packed {
      logic       push;
      logic       finish;
      logic [1:0] kind;
      logic [3:0] slot;
   } evt_type;

endpackage

`default_nettype wire

[rtl/mcitt_slot_ram.sv]
// Synchronous slot record memory with one write port and one registered read port.
`default_nettype none

module mcitt_slot_ram
   import mcitt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire slot_rec_type       wr_data,
   input  wire logic               rd_en,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output slot_rec_type            rd_data
);

   slot_rec_type mem [NUM_SLOTS];
   slot_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/mcitt_evt_out.sv]
// Result stage: holds the newest event so the final one of a request can be marked last.
`default_nettype none

module mcitt_evt_out
   import mcitt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire evt_type               evt,
   output logic                       evt_ok,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   logic             pend_valid_ff, pend_valid_in;
   logic [1:0]       pend_kind_ff, pend_kind_in;
   logic [3:0]       pend_slot_ff, pend_slot_in;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_kind_ff, out_kind_in;
   logic [3:0]       out_slot_ff, out_slot_in;
   logic             out_last_ff, out_last_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_free;
   logic             room;

   assign out_free = !out_valid_ff || rsp_tready;
   assign evt_ok   = !pend_valid_ff || out_free;
   assign room     = cnt_ff != CNT_W'(MAX_RESULTS);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_slot_in  = pend_slot_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_last_in   = out_last_ff;
      cnt_in        = cnt_ff;
      if (evt.push && evt_ok && room) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = pend_kind_ff;
            out_slot_in  = pend_slot_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_kind_in  = evt.kind;
         pend_slot_in  = evt.slot;
         cnt_in        = cnt_ff + CNT_W'(1);
      end else if (evt.finish && evt_ok) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = pend_kind_ff;
            out_slot_in  = pend_slot_ff;
            out_last_in  = 1'b1;
         end
         pend_valid_in = 1'b0;
         cnt_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      out_kind_ff  <= out_kind_in;
      out_slot_ff  <= out_slot_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 4){1'b0}}, out_slot_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

[rtl/mcitt_ctrl.sv]
// Request sequencer: slot walk, read-modify-write of slot records and in-use flags.
`default_nettype none

module mcitt_ctrl
   import mcitt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   output logic                       rd_en,
   output logic [IDX_W-1:0]           rd_addr,
   input  wire slot_rec_type          rd_data,
   output logic                       wr_en,
   output logic [IDX_W-1:0]           wr_addr,
   output slot_rec_type               wr_data,
   output evt_type                    evt,
   input  wire logic                  evt_ok
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_EVAL   = 3'd3;
   localparam logic [2:0] S_KILL   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [NUM_SLOTS-1:0] in_use_ff, in_use_in;
   logic [1:0]           op_ff;
   logic [31:0]          now_ff, period_ff, lifetime_ff;
   logic                 forever_ff, nfire_ff, nkill_ff;

   logic [3:0]           req_slot;
   logic                 slot_ok;
   logic                 accept;
   logic                 last_idx;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;
   logic                 due, expire;
   slot_rec_type         new_rec;

   assign req_slot   = req_tdata[3:0];
   assign slot_ok    = {2'b00, req_slot} < 6'(NUM_SLOTS);
   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign last_idx   = idx_ff == IDX_W'(NUM_SLOTS - 1);

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      new_rec.interval      = period_ff;
      new_rec.deadline      = {1'b0, now_ff} + {1'b0, period_ff};
      new_rec.expiry        = {1'b0, now_ff} + {1'b0, lifetime_ff};
      new_rec.never_expires = forever_ff;
      new_rec.fire_enable   = nfire_ff;
      new_rec.kill_enable   = nkill_ff;
   end

   assign due    = rd_data.deadline <= {1'b0, now_ff};
   assign expire = !rd_data.never_expires && (rd_data.expiry < {1'b0, now_ff});

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      in_use_in  = in_use_ff;
      evt        = '0;
      rd_en      = 1'b0;
      rd_addr    = idx_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rd_data;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (req_tuser == OP_START) begin
                  state_in = S_START;
               end else if (req_tuser == OP_KILL) begin
                  idx_in   = IDX_W'(req_slot);
                  state_in = slot_ok ? S_READ : S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_START: begin
            if (evt_ok) begin
               evt.push = 1'b1;
               state_in = S_FINISH;
               if (free_found) begin
                  evt.kind            = KIND_STARTED;
                  evt.slot            = 4'(free_idx);
                  wr_en               = 1'b1;
                  wr_addr             = free_idx;
                  wr_data             = new_rec;
                  in_use_in[free_idx] = 1'b1;
               end else begin
                  evt.kind = KIND_NOFREE;
                  evt.slot = 4'd0;
               end
            end
         end
         S_READ: begin
            if (in_use_ff[idx_ff]) begin
               rd_en    = 1'b1;
               state_in = (op_ff == OP_TICK) ? S_EVAL : S_KILL;
            end else if (op_ff == OP_KILL || last_idx) begin
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_EVAL: begin
            if (!(due && rd_data.fire_enable && !evt_ok)) begin
               if (due) begin
                  wr_en            = 1'b1;
                  wr_data.deadline = rd_data.deadline + {1'b0, rd_data.interval};
               end
               evt.push = due && rd_data.fire_enable;
               evt.kind = KIND_FIRED;
               evt.slot = 4'(idx_ff);
               if (expire) begin
                  state_in = S_KILL;
               end else if (last_idx) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         S_KILL: begin
            if (!(rd_data.kill_enable && !evt_ok)) begin
               in_use_in[idx_ff] = 1'b0;
               evt.push          = rd_data.kill_enable;
               evt.kind          = KIND_KILLED;
               evt.slot          = 4'(idx_ff);
               if (op_ff == OP_KILL || last_idx) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         S_FINISH: begin
            evt.finish = 1'b1;
            if (evt_ok) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         idx_ff    <= '0;
         in_use_ff <= '0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         in_use_ff <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_tuser;
         period_ff   <= req_tdata[35:4];
         lifetime_ff <= req_tdata[67:36];
         forever_ff  <= req_tdata[68];
         nfire_ff    <= req_tdata[69];
         nkill_ff    <= req_tdata[70];
         now_ff      <= req_tdata[102:71];
      end
   end

endmodule

`default_nettype wire

[rtl/multi_channel_interval_timer_table_core.sv]
// Top level of the multi-channel interval timer table.
//
//   Channel   Direction  Payload
//   req_*     in         tuser: op; tdata: slot, period, lifetime, forever_req,
//                        notify_fire, notify_kill, now
//   rsp_*     out        tuser: kind; tdata: timer_slot; tlast: last
//
// A start takes the lowest free slot and writes its record. A kill of a slot in use reads
// its record first and frees it; a kill of a free slot goes straight to the finish step.
// Tick and kill all walk the slots in order and read each record in use; a tick passes
// each slot that it retires on to the kill step, which frees it.
// Reset clears the in-use flags at once; the record memory needs no clearing pass.
// A stalled result channel holds the walk when the controller has a new event while both
// the pending and the output event registers are full.
`default_nettype none

module multi_channel_interval_timer_table_core
   import mcitt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // slot[3:0], period[35:4], lifetime[67:36], forever_req[68], notify_fire[69],
   // notify_kill[70], now[102:71], zero[103]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // timer_slot[3:0], zero[7:4]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // kind[1:0]
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   slot_rec_type     rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_rec_type     wr_data;
   evt_type          evt;
   logic             evt_ok;

   mcitt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .evt        (evt),
      .evt_ok     (evt_ok)
   );

   mcitt_slot_ram u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mcitt_evt_out u_evt_out (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .evt_ok     (evt_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[bench/timer_table_tb_pkg.sv]
// Request and event types and the event scoreboard for the timer table bench.
package timer_table_tb_pkg;
   import mcitt_pkg::*;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  slot;
      logic [31:0] period;
      logic [31:0] lifetime;
      logic        forever_req;
      logic        notify_fire;
      logic        notify_kill;
      logic [31:0] now;
   } timer_request_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] timer_slot;
      logic       last;
   } timer_event_type;

   class timer_event_board_type;
      bit          busy[NUM_SLOTS];
      logic [31:0] born[NUM_SLOTS];
      logic [31:0] span[NUM_SLOTS];
      logic [31:0] life[NUM_SLOTS];
      logic [32:0] due[NUM_SLOTS];
      bit          endless[NUM_SLOTS];
      bit          fire_on[NUM_SLOTS];
      bit          kill_on[NUM_SLOTS];

      timer_event_type awaited[$];
      timer_event_type fresh[$];
      int unsigned     mismatches;
      int unsigned     kind_count[4];

      function void add_event(logic [1:0] kind, int s);
         timer_event_type ev;
         ev.kind       = kind;
         ev.timer_slot = 4'(s);
         ev.last       = 1'b0;
         if (fresh.size() < MAX_RESULTS) fresh.push_back(ev);
      endfunction

      function void retire_slot(int s);
         if (s < NUM_SLOTS && busy[s]) begin
            busy[s] = 1'b0;
            if (kill_on[s]) add_event(KIND_KILLED, s);
         end
      endfunction

      function int any_busy_slot();
         int picks[$];
         for (int i = 0; i < NUM_SLOTS; i++) if (busy[i]) picks.push_back(i);
         if (picks.size() == 0) return -1;
         return picks[$urandom_range(0, picks.size() - 1)];
      endfunction

      // Works out the events of one accepted request and queues them.
      function void note_request(timer_request_type rq);
         int free_idx;
         fresh.delete();
         case (rq.op)
            OP_START: begin
               free_idx = -1;
               for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!busy[i]) free_idx = i;
               if (free_idx < 0) begin
                  add_event(KIND_NOFREE, 0);
               end else begin
                  busy[free_idx]    = 1'b1;
                  born[free_idx]    = rq.now;
                  span[free_idx]    = rq.period;
                  life[free_idx]    = rq.lifetime;
                  endless[free_idx] = rq.forever_req;
                  fire_on[free_idx] = rq.notify_fire;
                  kill_on[free_idx] = rq.notify_kill;
                  due[free_idx]     = {1'b0, rq.now} + {1'b0, rq.period};
                  add_event(KIND_STARTED, free_idx);
               end
            end
            OP_KILL: begin
               retire_slot(int'(rq.slot));
            end
            OP_TICK: begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (!busy[i]) continue;
                  if (due[i] <= {1'b0, rq.now}) begin
                     due[i] = due[i] + {1'b0, span[i]};
                     if (fire_on[i]) add_event(KIND_FIRED, i);
                  end
                  if (!endless[i] && ({1'b0, born[i]} + {1'b0, life[i]}) < {1'b0, rq.now})
                     retire_slot(i);
               end
            end
            default: begin
               for (int i = 0; i < NUM_SLOTS; i++) retire_slot(i);
            end
         endcase
         if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[k]) awaited.push_back(fresh[k]);
      endfunction

      function void check_event(logic [1:0] kind, logic [3:0] slot, logic last);
         timer_event_type want;
         if (awaited.size() == 0) begin
            $error("unexpected event: kind %0d, timer_slot %0d, last %0d", kind, slot, last);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            mismatches++;
         end
         if (slot !== want.timer_slot) begin
            $error("timer_slot: expected %0d, actual %0d", want.timer_slot, slot);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            mismatches++;
         end
         kind_count[want.kind]++;
      endfunction
   endclass

endpackage

[bench/tb_top.sv]
// Top-level bench for the timer table core: stimulus, response sink and end of run.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mcitt_pkg::*;
   import timer_table_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned DRAIN_TAIL  = 64;
   localparam int unsigned PHASE_ITEMS = 105;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tready = 1'b0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire [RSP_DATA_W-1:0]  rsp_tdata;
   wire [1:0]             rsp_tuser;
   wire                   rsp_tlast;

   timer_event_board_type board = new();

   int unsigned send_gap_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned cycle_count   = 0;
   logic [31:0] sim_now       = '0;

   multi_channel_interval_timer_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic timer_request_type compose_request(logic [1:0] op, logic [3:0] slot,
                                                         logic [31:0] period,
                                                         logic [31:0] lifetime,
                                                         logic fr, logic nf, logic nk,
                                                         logic [31:0] now);
      timer_request_type rq;
      rq.op          = op;
      rq.slot        = slot;
      rq.period      = period;
      rq.lifetime    = lifetime;
      rq.forever_req = fr;
      rq.notify_fire = nf;
      rq.notify_kill = nk;
      rq.now         = now;
      return rq;
   endfunction

   task automatic send_request(input timer_request_type rq);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.op;
      req_tdata  <= {1'b0, rq.now, rq.notify_kill, rq.notify_fire, rq.forever_req,
                     rq.lifetime, rq.period, rq.slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(rq);
      requests_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      send_request(compose_request(OP_KILL_ALL, 4'd0, '0, '0, 1'b0, 1'b0, 1'b0, '0));
      send_request(compose_request(OP_TICK, 4'hF, '1, '1, 1'b1, 1'b1, 1'b1, '0));
      send_request(compose_request(OP_KILL, 4'd5, '0, '0, 1'b0, 1'b0, 1'b0, '0));
      send_request(compose_request(OP_START, 4'd0, '0, '0, 1'b0, 1'b1, 1'b1, '0));
      send_request(compose_request(OP_START, 4'd9, '1, '1, 1'b0, 1'b1, 1'b1, '1));
      send_request(compose_request(OP_TICK, 4'd0, '0, '0, 1'b0, 1'b0, 1'b0, 32'd0));
      send_request(compose_request(OP_TICK, 4'd0, '0, '0, 1'b0, 1'b0, 1'b0, 32'd1));
      send_request(compose_request(OP_START, 4'd0, 32'd3, '0, 1'b1, 1'b0, 1'b0, 32'd10));
      for (int i = 0; i < NUM_SLOTS - 2; i++)
         send_request(compose_request(OP_START, 4'($urandom), $urandom_range(1, 20),
                                      $urandom_range(0, 100), 1'b0, 1'b1, 1'b1,
                                      $urandom_range(0, 1000)));
      send_request(compose_request(OP_START, 4'd3, 32'd7, 32'd7, 1'b0, 1'b1, 1'b1, 32'd5));
      send_request(compose_request(OP_TICK, 4'd0, '0, '0, 1'b0, 1'b0, 1'b0, '1));
      send_request(compose_request(OP_KILL, 4'd0, '0, '0, 1'b0, 1'b0, 1'b0, '0));
      send_request(compose_request(OP_KILL_ALL, 4'hF, '1, '1, 1'b1, 1'b1, 1'b1, '1));
   endtask

   task automatic run_random(input int unsigned count);
      timer_request_type rq;
      int unsigned       done;
      int unsigned       roll;
      int                pick;
      done = 0;
      while (done < count) begin
         roll           = $urandom_range(0, 99);
         rq.op          = 2'($urandom);
         rq.slot        = 4'($urandom);
         rq.period      = $urandom;
         rq.lifetime    = $urandom;
         rq.forever_req = 1'($urandom);
         rq.notify_fire = 1'($urandom);
         rq.notify_kill = 1'($urandom);
         rq.now         = $urandom;
         if (roll >= 8) begin
            rq.now = sim_now;
            if (roll < 44) begin
               rq.op = OP_START;
               if ($urandom_range(0, 4) != 0) rq.period = $urandom_range(0, 12);
               if ($urandom_range(0, 5) != 0) rq.lifetime = $urandom_range(0, 60);
               rq.forever_req = ($urandom_range(0, 3) == 0);
            end else if (roll < 76) begin
               rq.op   = OP_TICK;
               sim_now = sim_now + $urandom_range(0, 6);
               rq.now  = sim_now;
            end else if (roll < 97) begin
               rq.op = OP_KILL;
               pick  = board.any_busy_slot();
               if (pick >= 0 && $urandom_range(0, 3) != 0) rq.slot = 4'(pick);
            end else begin
               rq.op = OP_KILL_ALL;
            end
         end
         send_request(rq);
         done++;
      end
   endtask

   task automatic run_phase(input int unsigned gap, input int unsigned stall,
                            input logic [31:0] base_now);
      send_gap_pct  = gap;
      rsp_stall_pct = stall;
      sim_now       = base_now;
      run_random(PHASE_ITEMS);
      wait_drain();
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_event(rsp_tuser, rsp_tdata[3:0], rsp_tlast);
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_drain();
      run_phase(0, 0, 32'd0);
      run_phase(47, 0, $urandom);
      run_phase(0, 47, 32'd1000);
      run_phase(27, 27, 32'hFFFF_FF80);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (board.awaited.size() != 0)
         $error("%0d expected events never arrived", board.awaited.size());
      $display("Sent %0d requests (start, kill, tick, kill all, full table, 33-bit deadlines)",
               requests_sent);
      $display("under four idle mixes; events: %0d started, %0d no slot, %0d fired, %0d killed.",
               board.kind_count[KIND_STARTED], board.kind_count[KIND_NOFREE],
               board.kind_count[KIND_FIRED], board.kind_count[KIND_KILLED]);
      if (board.mismatches == 0 && board.awaited.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/mcitt_pkg.sv
rtl/mcitt_slot_ram.sv
rtl/mcitt_evt_out.sv
rtl/mcitt_ctrl.sv
rtl/multi_channel_interval_timer_table_core.sv
bench/timer_table_tb_pkg.sv
bench/tb_top.sv
